FILE: hdl/eda_pkg.sv
// shared constants, types and command bundle of the euclidean distance accumulator
package eda_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int ACC_BITS      = 48;
    localparam int FRACTION_BITS = 8;

    localparam int VALUE_BITS = 16;
    localparam int DIST_BITS  = 32;
    localparam int MAG_BITS   = SAMPLE_BITS + 1;
    localparam int SQ_BITS    = 2 * MAG_BITS;
    localparam int SUM_BITS   = ((ACC_BITS > SQ_BITS) ? ACC_BITS : SQ_BITS) + 1;
    localparam int SRC_BITS   = 2 * DIST_BITS;
    localparam int ROOT_ITERS = DIST_BITS + FRACTION_BITS;
    localparam int ROOT_BITS  = ROOT_ITERS;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int ITER_BITS  = $clog2(ROOT_ITERS);

    localparam logic [SUM_BITS-1:0] ACC_MAX =
        {{(SUM_BITS - ACC_BITS){1'b0}}, {ACC_BITS{1'b1}}};
    localparam logic [ITER_BITS-1:0] ITER_LAST = ITER_BITS'(ROOT_ITERS - 1);
    localparam logic [ROOT_BITS-1:0] DIST_MAX  =
        {{(ROOT_BITS - DIST_BITS){1'b0}}, {DIST_BITS{1'b1}}};

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_ROOT,
        ST_DONE
    } eda_state_t;

    typedef struct packed {
        logic load;       // capture a new element pair and square it
        logic accum;      // add the registered square into the sum
        logic root_init;  // seed the root engine with the new sum
        logic root_step;  // one digit of the root
        logic out_load;   // move the root into the output register
        logic clear;      // restart the sum and the overflow flag
    } eda_cmd_t;

endpackage

FILE: hdl/eda_ctrl.sv
// controller: input stage tracking, root sequencing and output register handshake
module eda_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output eda_pkg::eda_cmd_t cmd
);
    import eda_pkg::*;

    eda_state_t           state_reg, state_next;
    logic                 stage_valid_reg, stage_valid_next;
    logic                 stage_last_reg, stage_last_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ITER_BITS-1:0] iter_reg, iter_next;
    logic                 last_pending;
    logic                 accept;

    assign last_pending = stage_valid_reg && stage_last_reg;
    assign accept       = s_tvalid && s_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (last_pending)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (iter_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.accum     = stage_valid_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                s_tready      = !last_pending;
                cmd.root_init = last_pending;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = !out_valid_reg || m_tready;
                cmd.clear    = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        cmd.load = s_tvalid && s_tready;
    end

    always_comb
    begin
        stage_valid_next = accept;
        stage_last_next  = accept ? s_tlast : stage_last_reg;
        out_valid_next   = cmd.out_load || (out_valid_reg && !m_tready);
        iter_next        = iter_reg;
        if (cmd.root_init)
        begin
            iter_next = ITER_LAST;
        end
        else if (cmd.root_step && (iter_reg != '0))
        begin
            iter_next = iter_reg - ITER_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_ACCUM;
            stage_valid_reg <= 1'b0;
            stage_last_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            iter_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            stage_valid_reg <= stage_valid_next;
            stage_last_reg  <= stage_last_next;
            out_valid_reg   <= out_valid_next;
            iter_reg        <= iter_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // input is only taken while summing
    a_ready_in_accum: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == ST_ACCUM))
        else $error("input ready outside accumulate state");

    // a last pair in the square stage always starts the root
    a_last_starts_root: assert property (@(posedge clk) disable iff (!rst_n)
        last_pending |=> (state_reg == ST_ROOT))
        else $error("last pair did not start the root");

    // the root runs exactly its digit count
    a_root_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT && iter_reg == '0) |=> (state_reg == ST_DONE))
        else $error("root sequence did not finish on time");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten");

endmodule

FILE: hdl/eda_datapath.sv
// datapath: squared difference, saturating sum, bit-serial square root, output register
module eda_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  eda_pkg::eda_cmd_t                cmd,
    input  logic [eda_pkg::VALUE_BITS-1:0]   x_value,
    input  logic                             x_present,
    input  logic [eda_pkg::VALUE_BITS-1:0]   y_value,
    input  logic                             y_present,
    output logic [eda_pkg::DIST_BITS-1:0]    distance,
    output logic                             overflow
);
    import eda_pkg::*;

    logic signed [SAMPLE_BITS:0] x_s, y_s, diff;
    logic [MAG_BITS-1:0]         mag;
    logic [SQ_BITS-1:0]          sq_reg;
    logic [ACC_BITS-1:0]         acc_reg, acc_next;
    logic                        sat_reg, sat_next;
    logic [SUM_BITS-1:0]         sum;
    logic                        sum_ovf;
    logic [ACC_BITS-1:0]         acc_add;
    logic [SRC_BITS-1:0]         src_reg;
    logic [ROOT_BITS-1:0]        root_reg;
    logic [REM_BITS-1:0]         rem_reg;
    logic [REM_BITS-1:0]         rem_shift, trial;
    logic                        digit;
    logic [DIST_BITS-1:0]        dist_reg;
    logic                        ovf_reg;

    // absent elements count as zero
    always_comb
    begin
        x_s  = x_present ? (SAMPLE_BITS + 1)'(signed'(x_value[SAMPLE_BITS-1:0])) : '0;
        y_s  = y_present ? (SAMPLE_BITS + 1)'(signed'(y_value[SAMPLE_BITS-1:0])) : '0;
        diff = x_s - y_s;
        mag  = diff[SAMPLE_BITS] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sq_reg <= mag * mag;
        end
    end

    // saturating sum
    always_comb
    begin
        sum      = SUM_BITS'(acc_reg) + SUM_BITS'(sq_reg);
        sum_ovf  = sum > ACC_MAX;
        acc_add  = sum_ovf ? {ACC_BITS{1'b1}} : sum[ACC_BITS-1:0];
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (cmd.clear)
        begin
            acc_next = '0;
            sat_next = 1'b0;
        end
        else if (cmd.accum)
        begin
            acc_next = acc_add;
            sat_next = sat_reg || sum_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            sat_reg <= sat_next;
        end
    end

    // restoring root, two sum bits per digit, zero pairs for the fraction
    always_comb
    begin
        rem_shift = {rem_reg[REM_BITS-3:0], src_reg[SRC_BITS-1 -: 2]};
        trial     = {root_reg, 2'b01};
        digit     = rem_shift >= trial;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_init)
        begin
            src_reg  <= SRC_BITS'(acc_next);
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cmd.root_step)
        begin
            src_reg  <= {src_reg[SRC_BITS-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_BITS-2:0], digit};
            rem_reg  <= digit ? (rem_shift - trial) : rem_shift;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            dist_reg <= (root_reg > DIST_MAX) ? {DIST_BITS{1'b1}} : root_reg[DIST_BITS-1:0];
            ovf_reg  <= sat_reg;
        end
    end

    assign distance = dist_reg;
    assign overflow = ovf_reg;

endmodule

FILE: hdl/euclidean_distance_accumulator.sv
// top level of the euclidean distance accumulator
// Each input transfer carries one element pair of two vectors with a presence flag per
// element; an absent element counts as zero. The squared difference is added into a
// 48-bit saturating sum at one pair per clock: the pair is squared in the cycle it is
// accepted and added in the cycle after. The transfer with tlast set closes the vector:
// input is then held off while a bit-serial restoring square root produces one result
// digit per cycle, 40 digits (32 integer plus 8 fraction bits), and the next vector can
// start in the cycle that the result is first offered. The result is
// floor(sqrt(sum) * 256), clamped to 32 bits, with a flag that says the sum saturated.
// It sits in an output register; the next vector is accepted while it waits, and only a
// second finished root waits for the first result to be taken.
module euclidean_distance_accumulator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // x_value [15:0], y_value [31:16]
    input  logic [1:0]  s_tuser,   // x_present [0], y_present [1]
    input  logic        s_tlast,   // last element pair of the vectors
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // distance [31:0], 8 fraction bits
    output logic        m_tuser    // overflow [0]
);
    import eda_pkg::*;

    eda_cmd_t cmd;

    eda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    eda_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .x_value   (s_tdata[VALUE_BITS-1:0]),
        .x_present (s_tuser[0]),
        .y_value   (s_tdata[2*VALUE_BITS-1:VALUE_BITS]),
        .y_present (s_tuser[1]),
        .distance  (m_tdata),
        .overflow  (m_tuser)
    );

endmodule

FILE: tb/tb.sv
// testbench of the euclidean distance accumulator: directed table, long saturation vectors, random vectors
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACC_W       = eda_pkg::ACC_BITS;
    localparam int FRAC_W      = eda_pkg::FRACTION_BITS;
    localparam int DIST_W      = eda_pkg::DIST_BITS;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 60;
    localparam int HOLD_LEN    = 400;
    localparam int N_DIRECTED  = 18;
    // sum of 65538 full-scale squares sits 196605 below the top of the sum
    localparam int N_FULL_SCALE = 65538;

    typedef struct packed {
        logic [15:0] x;
        logic        xp;
        logic [15:0] y;
        logic        yp;
        logic        last;
    } pair_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } result_t;

    typedef struct packed {
        pair_t   p;
        logic    pinned;   // expected result written into the row
        result_t want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;    // x_value [15:0], y_value [31:16]
    logic [1:0]  s_tuser = '0;    // x_present [0], y_present [1]
    logic        s_tlast = 1'b0;  // last element pair of the vectors
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // distance [31:0]
    logic        m_tuser;         // overflow [0]

    euclidean_distance_accumulator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state: running sum and its saturation flag
    logic [ACC_W-1:0] sum_sq = '0;
    logic             sum_sat = 1'b0;

    result_t distance_q [$];     // results still to come, oldest first
    row_t    pinned_q [$];       // per offered transfer: fixed expectation, if any
    int      fail_count = 0;
    int      send_idle = 8;      // percent of cycles the sender idles
    int      recv_idle = 79;     // percent of cycles the receiver stalls
    bit      hold_req = 1'b0;    // asks the receiver for a long hold-off

    // floor(sqrt(s) * 2^FRAC_W) by restoring root, two bits of the radicand per digit
    function automatic logic [DIST_W-1:0] scaled_isqrt(input logic [ACC_W-1:0] s);
        logic [63:0]       rad;
        logic [DIST_W-1:0] root;
        logic [35:0]       rem;
        logic [35:0]       trial;
        rad  = 64'(s) << (2 * FRAC_W);
        root = '0;
        rem  = '0;
        for (int i = 31; i >= 0; i--)
        begin
            rem   = {rem[33:0], rad[2*i +: 2]};
            trial = {2'b00, root, 2'b01};
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = {root[DIST_W-2:0], 1'b1};
            end
            else
            begin
                root = {root[DIST_W-2:0], 1'b0};
            end
        end
        return root;
    endfunction

    // add one pair to the running sum; on the last pair hand back the distance
    function automatic void accumulate_pair(input pair_t p, output bit done,
                                            output result_t r);
        logic signed [16:0] xv;
        logic signed [16:0] yv;
        logic signed [16:0] d;
        logic [16:0]        mag;
        logic [ACC_W-1:0]   sq;
        logic [ACC_W-1:0]   top;
        xv  = p.xp ? {p.x[15], p.x} : 17'sd0;
        yv  = p.yp ? {p.y[15], p.y} : 17'sd0;
        d   = xv - yv;
        mag = d[16] ? 17'(-d) : 17'(d);
        sq  = ACC_W'(mag) * ACC_W'(mag);
        top = {ACC_W{1'b1}};
        if (sq > top - sum_sq)
        begin
            sum_sq  = top;
            sum_sat = 1'b1;
        end
        else
        begin
            sum_sq = sum_sq + sq;
        end
        done = p.last;
        r    = '0;
        if (p.last)
        begin
            r.distance = scaled_isqrt(sum_sq);
            r.overflow = sum_sat;
            sum_sq     = '0;
            sum_sat    = 1'b0;
        end
    endfunction

    // offer one pair and return at the edge where it transfers
    task automatic send_pair(input pair_t p, input bit pinned, input result_t want);
        row_t tag;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        tag.p      = p;
        tag.pinned = pinned;
        tag.want   = want;
        pinned_q.push_back(tag);
        s_tvalid <= 1'b1;
        s_tdata  <= {p.y, p.x};
        s_tuser  <= {p.yp, p.xp};
        s_tlast  <= p.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4, 5: return 16'($urandom_range(64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(input int len);
        pair_t p;
        for (int k = 0; k < len; k++)
        begin
            p.x    = pick_sample();
            p.xp   = ($urandom_range(3) != 0);
            p.y    = pick_sample();
            p.yp   = ($urandom_range(3) != 0);
            p.last = (k == len - 1);
            send_pair(p, 1'b0, '0);
        end
    endtask

    // whole vectors until at least n pairs have gone out; mostly short, a few long
    task automatic run_random(input int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
            send_vector(len);
            sent += len;
        end
    endtask

    // one vector of full-scale pairs, then the tail pairs, the final one marked last
    task automatic send_full_scale(input int count, input logic [15:0] tail [],
                                   input result_t want);
        pair_t p;
        p = '{x: 16'h7FFF, xp: 1'b1, y: 16'h8000, yp: 1'b1, last: 1'b0};
        for (int k = 0; k < count; k++)
        begin
            p.last = (tail.size() == 0) && (k == count - 1);
            send_pair(p, p.last, want);
        end
        foreach (tail[k])
        begin
            p = '{x: tail[k], xp: 1'b1, y: 16'h0000, yp: 1'b1,
                  last: (k == tail.size() - 1)};
            send_pair(p, p.last, want);
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold     = HOLD_LEN;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // scoreboard: predict on every input transfer, check every output transfer
    always @(posedge clk)
    begin
        row_t    tag;
        result_t got;
        result_t exp_r;
        result_t pred;
        pair_t   p;
        bit      done;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.distance = m_tdata;
                got.overflow = m_tuser;
                if (distance_q.size() == 0)
                begin
                    $error("result transfer with no result expected: distance %0d", m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_r = distance_q.pop_front();
                    if (got.distance !== exp_r.distance)
                    begin
                        $error("distance: expected %0d, got %0d", exp_r.distance, got.distance);
                        fail_count++;
                    end
                    if (got.overflow !== exp_r.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d", exp_r.overflow, got.overflow);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                p.x    = s_tdata[15:0];
                p.y    = s_tdata[31:16];
                p.xp   = s_tuser[0];
                p.yp   = s_tuser[1];
                p.last = s_tlast;
                accumulate_pair(p, done, pred);
                tag = pinned_q.pop_front();
                if (done)
                    distance_q.push_back(tag.pinned ? tag.want : pred);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet == STALL_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    row_t directed_rows [N_DIRECTED];

    initial
    begin
        logic [15:0] tail_exact [];
        logic [15:0] tail_none [];
        directed_rows = '{
            // both absent right after reset
            '{'{16'h0000, 1'b0, 16'h0000, 1'b0, 1'b1}, 1'b1, '{32'd0, 1'b0}},
            // one side absent counts as zero
            '{'{16'h0003, 1'b1, 16'h0000, 1'b0, 1'b1}, 1'b1, '{32'd768, 1'b0}},
            '{'{16'h0000, 1'b0, 16'hFFFC, 1'b1, 1'b1}, 1'b1, '{32'd1024, 1'b0}},
            // largest difference both ways, then equal values
            '{'{16'h7FFF, 1'b1, 16'h8000, 1'b1, 1'b1}, 1'b1, '{32'd16776960, 1'b0}},
            '{'{16'h8000, 1'b1, 16'h7FFF, 1'b1, 1'b1}, 1'b1, '{32'd16776960, 1'b0}},
            '{'{16'h8000, 1'b1, 16'h8000, 1'b1, 1'b1}, 1'b1, '{32'd0, 1'b0}},
            // values of absent elements are ignored
            '{'{16'h04D2, 1'b0, 16'hFFFB, 1'b0, 1'b1}, 1'b1, '{32'd0, 1'b0}},
            // three-pair vector, 1 + 4 + 4
            '{'{16'h0001, 1'b1, 16'h0000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'h0002, 1'b1, 16'h0000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'h0000, 1'b1, 16'h0002, 1'b1, 1'b1}, 1'b1, '{32'd768, 1'b0}},
            // mixed presence and signs, from the predictor
            '{'{16'h7FFF, 1'b1, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
            '{'{16'h0000, 1'b0, 16'h8000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'hFFFF, 1'b1, 16'h0001, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'h0064, 1'b1, 16'hFF9C, 1'b1, 1'b1}, 1'b0, '0},
            '{'{16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0}, 1'b0, '0},
            '{'{16'h5555, 1'b1, 16'hAAAA, 1'b1, 1'b1}, 1'b0, '0},
            // both absent in the middle and at the end
            '{'{16'hAAAA, 1'b0, 16'h5555, 1'b0, 1'b0}, 1'b0, '0},
            '{'{16'h0000, 1'b0, 16'h0000, 1'b0, 1'b1}, 1'b1, '{32'd0, 1'b0}}
        };
        // 443^2 + 18^2 + 4^2 + 4^2 = 196605 lands the sum exactly on its maximum
        tail_exact = '{16'd443, 16'd18, 16'd4, 16'd4};
        tail_none  = new[0];

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_pair(directed_rows[i].p, directed_rows[i].pinned, directed_rows[i].want);

        // sender idles little, receiver a lot
        run_random(450);

        // receiver holds off while short vectors keep coming, so input backs up
        hold_req = 1'b1;
        for (int v = 0; v < 20; v++)
            send_vector($urandom_range(3, 1));

        send_idle = 79;
        recv_idle = 8;
        run_random(550);

        // long vectors run without idling: exact maximum, then past it
        send_idle = 0;
        recv_idle = 0;
        send_full_scale(N_FULL_SCALE, tail_exact, '{32'hFFFF_FFFF, 1'b0});
        send_full_scale(N_FULL_SCALE + 2, tail_none, '{32'hFFFF_FFFF, 1'b1});

        // neither side idles; the first vector here shows the flag was cleared
        run_random(550);

        s_tvalid <= 1'b0;
        while (distance_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
